FILE: sv/glo_pkg.sv
package glo_pkg;

    localparam int POS_W  = 12;
    localparam int REG_W  = 13;
    localparam int CLR_W  = 8;
    localparam int QUO_W  = 13;
    localparam int HI_W   = 14;
    localparam int LOP_W  = 25;
    localparam int HIP_W  = 27;
    localparam int NUM_W  = REG_W + QUO_W;
    localparam int KS_W   = REG_W + QUO_W;
    localparam int IN_W   = 2 * POS_W + 3 * CLR_W;
    localparam int OUT_W  = 3 * CLR_W;
    localparam int CFG_AW = 3;
    localparam int AXES   = 2;

    localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COLS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ROWS   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_THICK  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_RED    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_GREEN  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_BLUE   = 3'd7;

    localparam logic [REG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [REG_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [REG_W-1:0] COLS_RST   = 13'd2;
    localparam logic [REG_W-1:0] ROWS_RST   = 13'd2;
    localparam logic [REG_W-1:0] THICK_RST  = 13'd1;
    localparam logic [CLR_W-1:0] COLOR_RST  = 8'd0;

    typedef struct packed {
        logic [CLR_W-1:0] blue;
        logic [CLR_W-1:0] green;
        logic [CLR_W-1:0] red;
    } pix_t;

    typedef struct packed {
        logic fix;
        logic chk;
    } axis_flag_t;

endpackage

FILE: sv/grid_line_overlay.sv
// Grid line overlay for an RGB pixel stream.
// Slave stream s_*: one pixel per transfer with its column, row and colour.
// Master stream m_*: one pixel per transfer, either the input colour or the
// line colour, with m_tuser high when the line colour was substituted.
// Configuration: cfg_wr_en/cfg_addr/cfg_wr_data write one register per clock;
// the registers are read live by every stage, so write them only while the
// pipeline is empty.
// Throughput: one pixel per clock while m_tready does not hold the output. A
// pixel passes the input, multiply, numerator, divider, k and output stages.
// Depth is set by the 13-step restoring divider pipeline that
// finds the first line index at or past the pixel's window, one quotient
// bit per stage, followed by the multiply-back and compare stages.
// Reset: all stages empty, registers at 640x480, two parts each way,
// thickness one, black lines.
// Stall: when m_tready is low the output holds; earlier stages keep
// advancing into empty slots, and s_tready drops only once every stage is
// occupied.
module grid_line_overlay #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // column[11:0], row[23:12], in_red[31:24], in_green[39:32], in_blue[47:40]
    input  logic [glo_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [glo_pkg::OUT_W-1:0]    m_tdata,
    // on_line[0]
    output logic                         m_tuser,
    input  logic                         cfg_wr_en,
    input  logic [glo_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [glo_pkg::REG_W-1:0]    cfg_wr_data
);

    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_NUM  = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_KS   = ST_DIV0 + glo_pkg::QUO_W;
    localparam int ST_OUT  = ST_KS + 1;
    localparam int NS      = ST_OUT + 1;

    localparam int POS_W = glo_pkg::POS_W;
    localparam int REG_W = glo_pkg::REG_W;
    localparam int CLR_W = glo_pkg::CLR_W;
    localparam int QUO_W = glo_pkg::QUO_W;
    localparam int HI_W  = glo_pkg::HI_W;
    localparam int LOP_W = glo_pkg::LOP_W;
    localparam int HIP_W = glo_pkg::HIP_W;
    localparam int NUM_W = glo_pkg::NUM_W;
    localparam int KS_W  = glo_pkg::KS_W;
    localparam int AXES  = glo_pkg::AXES;

    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic [REG_W-1:0] cols_reg;
    logic [REG_W-1:0] rows_reg;
    logic [REG_W-1:0] thick_reg;
    logic [CLR_W-1:0] red_reg;
    logic [CLR_W-1:0] green_reg;
    logic [CLR_W-1:0] blue_reg;

    logic [REG_W-1:0] size_eff [AXES];
    logic [REG_W-1:0] parts    [AXES];
    logic [POS_W-1:0] pos_in   [AXES];
    glo_pkg::pix_t    pix_in;
    glo_pkg::pix_t    line_pix;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    glo_pkg::pix_t       pix_reg  [ST_IN:ST_KS];
    glo_pkg::axis_flag_t flag_reg [ST_IN:ST_KS][AXES];
    logic [POS_W-1:0]    lo_reg   [AXES];
    logic [HI_W-1:0]     hi_reg   [AXES];
    logic [LOP_W-1:0]    lop_reg  [AXES];
    logic [HIP_W-1:0]    hip_reg  [ST_MUL:ST_KS][AXES];
    logic [REG_W-1:0]    rem_reg  [ST_NUM:ST_KS-1][AXES];
    logic [QUO_W-1:0]    low_reg  [ST_NUM:ST_KS-1][AXES];
    logic [QUO_W-1:0]    q_reg    [ST_NUM:ST_KS-1][AXES];
    logic [KS_W-1:0]     ks_reg   [AXES];
    glo_pkg::pix_t       out_pix_reg;
    logic                out_on_reg;

    glo_pkg::axis_flag_t flag_in_next [AXES];
    logic [POS_W-1:0]    lo_next      [AXES];
    logic [HI_W-1:0]     hi_next      [AXES];
    logic [LOP_W-1:0]    lop_next     [AXES];
    logic [HIP_W-1:0]    hip_next     [AXES];
    logic [NUM_W-1:0]    num_next     [AXES];
    logic [REG_W-1:0]    rem_next     [ST_DIV0:ST_KS-1][AXES];
    logic [QUO_W-1:0]    low_next     [ST_DIV0:ST_KS-1][AXES];
    logic [QUO_W-1:0]    q_next       [ST_DIV0:ST_KS-1][AXES];
    glo_pkg::axis_flag_t flag_ks_next [AXES];
    logic [KS_W-1:0]     ks_next      [AXES];
    logic [AXES-1:0]     hit;
    logic                on_next;
    glo_pkg::pix_t       out_pix_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= glo_pkg::WIDTH_RST;
            height_reg <= glo_pkg::HEIGHT_RST;
            cols_reg   <= glo_pkg::COLS_RST;
            rows_reg   <= glo_pkg::ROWS_RST;
            thick_reg  <= glo_pkg::THICK_RST;
            red_reg    <= glo_pkg::COLOR_RST;
            green_reg  <= glo_pkg::COLOR_RST;
            blue_reg   <= glo_pkg::COLOR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                glo_pkg::REG_WIDTH:  width_reg  <= cfg_wr_data;
                glo_pkg::REG_HEIGHT: height_reg <= cfg_wr_data;
                glo_pkg::REG_COLS:   cols_reg   <= cfg_wr_data;
                glo_pkg::REG_ROWS:   rows_reg   <= cfg_wr_data;
                glo_pkg::REG_THICK:  thick_reg  <= cfg_wr_data;
                glo_pkg::REG_RED:    red_reg    <= cfg_wr_data[CLR_W-1:0];
                glo_pkg::REG_GREEN:  green_reg  <= cfg_wr_data[CLR_W-1:0];
                glo_pkg::REG_BLUE:   blue_reg   <= cfg_wr_data[CLR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        size_eff[0] = (int'(width_reg) > MAX_WIDTH) ? REG_W'(MAX_WIDTH) : width_reg;
        size_eff[1] = (int'(height_reg) > MAX_HEIGHT) ? REG_W'(MAX_HEIGHT) : height_reg;
        parts[0]    = cols_reg;
        parts[1]    = rows_reg;
        pos_in[0]   = s_tdata[POS_W-1:0];
        pos_in[1]   = s_tdata[2*POS_W-1:POS_W];
        pix_in.red   = s_tdata[2*POS_W +: CLR_W];
        pix_in.green = s_tdata[2*POS_W+CLR_W +: CLR_W];
        pix_in.blue  = s_tdata[2*POS_W+2*CLR_W +: CLR_W];
        line_pix.red   = red_reg;
        line_pix.green = green_reg;
        line_pix.blue  = blue_reg;
    end

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    // first stage: window [pos-thick+1, pos+thick-1] and the trivial cases
    always_comb
    begin
        logic [REG_W-1:0] pos_ext;
        logic             lines;
        logic             at_or_past;
        for (int a = 0; a < AXES; a++)
        begin
            pos_ext    = REG_W'(pos_in[a]);
            lines      = (parts[a] >= REG_W'(2)) && (thick_reg != '0);
            at_or_past = pos_ext >= thick_reg;
            lo_next[a] = at_or_past ? POS_W'(pos_ext + REG_W'(1) - thick_reg) : '0;
            hi_next[a] = HI_W'(pos_in[a]) + HI_W'(thick_reg);
            flag_in_next[a].fix = lines && (size_eff[a] == '0) && !at_or_past;
            flag_in_next[a].chk = lines && (size_eff[a] != '0)
                                  && (REG_W'(lo_next[a]) < size_eff[a]);
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            lop_next[a] = LOP_W'(lo_reg[a]) * LOP_W'(parts[a]);
            hip_next[a] = HIP_W'(hi_reg[a]) * HIP_W'(parts[a]);
            num_next[a] = flag_reg[ST_MUL][a].chk
                          ? NUM_W'(lop_reg[a]) + NUM_W'(size_eff[a]) - NUM_W'(1)
                          : '0;
        end
    end

    // one quotient bit per stage: ceil(lo*parts/size)
    always_comb
    begin
        logic [REG_W:0] t;
        logic           ge;
        for (int s = ST_DIV0; s < ST_KS; s++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                t  = {rem_reg[s-1][a], low_reg[s-1][a][QUO_W-1]};
                ge = t >= {1'b0, size_eff[a]};
                rem_next[s][a] = ge ? REG_W'(t - {1'b0, size_eff[a]}) : t[REG_W-1:0];
                q_next[s][a]   = {q_reg[s-1][a][QUO_W-2:0], ge};
                low_next[s][a] = {low_reg[s-1][a][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [QUO_W-1:0] kmin;
        for (int a = 0; a < AXES; a++)
        begin
            kmin = (q_reg[ST_KS-1][a] == '0) ? QUO_W'(1) : q_reg[ST_KS-1][a];
            flag_ks_next[a].fix = flag_reg[ST_KS-1][a].fix;
            flag_ks_next[a].chk = flag_reg[ST_KS-1][a].chk && (REG_W'(kmin) < parts[a]);
            ks_next[a] = KS_W'(size_eff[a]) * KS_W'(kmin);
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            hit[a] = flag_reg[ST_KS][a].fix
                     || (flag_reg[ST_KS][a].chk
                         && (HIP_W'(ks_reg[a]) < hip_reg[ST_KS][a]));
        end
        on_next      = |hit;
        out_pix_next = on_next ? line_pix : pix_reg[ST_KS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            pix_reg[ST_IN] <= pix_in;
            for (int a = 0; a < AXES; a++)
            begin
                flag_reg[ST_IN][a] <= flag_in_next[a];
                lo_reg[a]          <= lo_next[a];
                hi_reg[a]          <= hi_next[a];
            end
        end
        if (en[ST_MUL])
        begin
            pix_reg[ST_MUL] <= pix_reg[ST_IN];
            for (int a = 0; a < AXES; a++)
            begin
                flag_reg[ST_MUL][a] <= flag_reg[ST_IN][a];
                lop_reg[a]          <= lop_next[a];
                hip_reg[ST_MUL][a]  <= hip_next[a];
            end
        end
        if (en[ST_NUM])
        begin
            pix_reg[ST_NUM] <= pix_reg[ST_MUL];
            for (int a = 0; a < AXES; a++)
            begin
                flag_reg[ST_NUM][a] <= flag_reg[ST_MUL][a];
                hip_reg[ST_NUM][a]  <= hip_reg[ST_MUL][a];
                rem_reg[ST_NUM][a]  <= num_next[a][NUM_W-1:QUO_W];
                low_reg[ST_NUM][a]  <= num_next[a][QUO_W-1:0];
                q_reg[ST_NUM][a]    <= '0;
            end
        end
        for (int s = ST_DIV0; s < ST_KS; s++)
        begin
            if (en[s])
            begin
                pix_reg[s] <= pix_reg[s-1];
                for (int a = 0; a < AXES; a++)
                begin
                    flag_reg[s][a] <= flag_reg[s-1][a];
                    hip_reg[s][a]  <= hip_reg[s-1][a];
                    rem_reg[s][a]  <= rem_next[s][a];
                    low_reg[s][a]  <= low_next[s][a];
                    q_reg[s][a]    <= q_next[s][a];
                end
            end
        end
        if (en[ST_KS])
        begin
            pix_reg[ST_KS] <= pix_reg[ST_KS-1];
            for (int a = 0; a < AXES; a++)
            begin
                flag_reg[ST_KS][a] <= flag_ks_next[a];
                hip_reg[ST_KS][a]  <= hip_reg[ST_KS-1][a];
                ks_reg[a]          <= ks_next[a];
            end
        end
        if (en[ST_OUT])
        begin
            out_pix_reg <= out_pix_next;
            out_on_reg  <= on_next;
        end
    end

    assign s_tready = en[ST_IN];
    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_on_reg;

    a_full_when_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input blocked while pipeline has a free slot");

    a_accept_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[ST_IN]
    ) else $error("accepted pixel missing from first stage");

    a_drain_to_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[ST_KS] && !m_tvalid) |=> m_tvalid
    ) else $error("result did not move into empty output register");

endmodule
